// ===== sv/atfp_pkg.sv =====
// Shared types and byte codes for the attitude text frame parser.
// No dependencies; imported by atfp_step and the core.
package atfp_pkg;

    localparam logic [7:0] BYTE_START = 8'd61;
    localparam logic [7:0] BYTE_NL    = 8'd10;
    localparam logic [7:0] BYTE_COMMA = 8'd44;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_POINT = 8'd46;
    localparam logic [7:0] BYTE_MINUS = 8'd45;
    localparam logic [7:0] BYTE_ZERO  = 8'd48;
    localparam logic [7:0] BYTE_NINE  = 8'd57;

    localparam logic [14:0] MAG_MAX = 15'h7FFF;

    localparam logic [1:0] FIELD_X = 2'd0;
    localparam logic [1:0] FIELD_Y = 2'd1;
    localparam logic [1:0] FIELD_Z = 2'd2;

    typedef struct packed {
        logic        in_frame;
        logic        data_ended;
        logic [1:0]  field_number;
        logic        at_field_start;
        logic        field_negative;
        logic [14:0] magnitude;
        logic [15:0] first_value;
        logic [15:0] second_value;
        logic        saturated_seen;
    } parse_state_t;

    typedef struct packed {
        logic        overflow;
        logic [15:0] angle_z;
        logic [15:0] angle_y;
        logic [15:0] angle_x;
    } frame_result_t;

    localparam parse_state_t STATE_RESET = '{
        in_frame:       1'b0,
        data_ended:     1'b0,
        field_number:   FIELD_X,
        at_field_start: 1'b1,
        field_negative: 1'b0,
        magnitude:      15'd0,
        first_value:    16'd0,
        second_value:   16'd0,
        saturated_seen: 1'b0
    };

endpackage

// ===== sv/attitude_text_frame_parser_core.sv =====
// Attitude text frame parser core: input byte register, parse state, result register.
// Depends on atfp_pkg and atfp_step.
//
// A '\n' byte goes through the input byte register, atfp_step and the result register.
// Throughput: one byte per cycle unless output is stalled; the whole parse step is one
// pass of atfp_step between the input byte register and the state/result registers.
// Reset (rst_n low, asynchronous): both stages empty, parser idle outside a frame.
module attitude_text_frame_parser_core
    import atfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input byte request
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // result request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata     // [15:0] angle_x, [31:16] angle_y,
                                    // [47:32] angle_z, [48] overflow, [55:49] zero
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    logic          out_valid_reg;
    frame_result_t out_data_reg;
    frame_result_t step_result;
    logic          step_emit;
    logic          advance;

    // The byte stage moves on whenever the result register is empty or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    atfp_step u_step (
        .state_cur (state_reg),
        .rx_byte   (in_byte_reg),
        .state_nxt (state_next),
        .emit      (step_emit),
        .result    (step_result)
    );

    // Input register: hold the byte until the parse step consumes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // Parse state: advance once per consumed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (in_valid_reg && advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: load on a frame end, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && step_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && step_emit)
        begin
            out_data_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

`ifndef SYNTH
    // The field index never passes the third field.
    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.field_number != 2'd3)
        else $error("field index out of range");

    // A result appears only right after a newline byte was consumed.
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_byte_reg == BYTE_NL))
        else $error("result without newline");

    // Saturated magnitudes never produce the most negative code.
    a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.angle_x != 16'h8000 &&
                           out_data_reg.angle_y != 16'h8000 &&
                           out_data_reg.angle_z != 16'h8000))
        else $error("angle outside saturation range");

    // Back-pressure on the input only comes from a stalled full pipeline.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without cause");
`endif

endmodule

// ===== sv/atfp_step.sv =====
// Next-state and result logic for one received byte of an attitude frame.
// Depends on atfp_pkg for the state and result types.
module atfp_step
    import atfp_pkg::*;
(
    input  parse_state_t  state_cur,
    input  logic [7:0]    rx_byte,
    output parse_state_t  state_nxt,
    output logic          emit,
    output frame_result_t result
);

    logic [15:0] cur_value;
    logic [18:0] acc_sum;
    logic [3:0]  digit;
    logic        is_digit;

    always_comb
    begin
        cur_value = state_cur.field_negative ? (16'd0 - {1'b0, state_cur.magnitude})
                                             : {1'b0, state_cur.magnitude};
        is_digit  = rx_byte inside {[BYTE_ZERO:BYTE_NINE]};
        digit     = 4'(rx_byte - BYTE_ZERO);
        // magnitude * 10 + digit
        acc_sum   = ({4'd0, state_cur.magnitude} << 3) + ({4'd0, state_cur.magnitude} << 1)
                  + {15'd0, digit};
    end

    always_comb
    begin
        state_nxt = state_cur;
        emit      = 1'b0;
        result    = '0;
        if (rx_byte == BYTE_START)
        begin
            state_nxt          = STATE_RESET;
            state_nxt.in_frame = 1'b1;
        end
        else if (state_cur.in_frame)
        begin
            if (rx_byte == BYTE_NL)
            begin
                emit               = 1'b1;
                state_nxt.in_frame = 1'b0;
                result.overflow    = state_cur.saturated_seen;
                result.angle_x     = state_cur.first_value;
                case (state_cur.field_number)
                    FIELD_X:
                    begin
                        result.angle_x = state_cur.data_ended ? state_cur.first_value
                                                              : cur_value;
                    end
                    FIELD_Y:
                    begin
                        result.angle_y = state_cur.data_ended ? state_cur.second_value
                                                              : cur_value;
                    end
                    default:
                    begin
                        result.angle_y = state_cur.second_value;
                        result.angle_z = cur_value;
                    end
                endcase
            end
            else if (!state_cur.data_ended)
            begin
                if (rx_byte == BYTE_CR || rx_byte == BYTE_COMMA)
                begin
                    case (state_cur.field_number)
                        FIELD_X: state_nxt.first_value  = cur_value;
                        FIELD_Y: state_nxt.second_value = cur_value;
                        default: ;
                    endcase
                    if (rx_byte == BYTE_CR || state_cur.field_number == FIELD_Z)
                    begin
                        state_nxt.data_ended = 1'b1;
                    end
                    else
                    begin
                        state_nxt.field_number   = state_cur.field_number + 2'd1;
                        state_nxt.at_field_start = 1'b1;
                        state_nxt.field_negative = 1'b0;
                        state_nxt.magnitude      = 15'd0;
                    end
                end
                else
                begin
                    if (rx_byte == BYTE_MINUS && state_cur.at_field_start)
                    begin
                        state_nxt.field_negative = 1'b1;
                    end
                    else if (is_digit)
                    begin
                        if (acc_sum > {4'd0, MAG_MAX})
                        begin
                            state_nxt.magnitude      = MAG_MAX;
                            state_nxt.saturated_seen = 1'b1;
                        end
                        else
                        begin
                            state_nxt.magnitude = acc_sum[14:0];
                        end
                    end
                    // '.' and other bytes only consume the field start
                    state_nxt.at_field_start = 1'b0;
                end
            end
        end
    end

endmodule
